// ===== hdl/ils_pkg.sv =====
// Package for the integer literal scanner: phase type, error codes and character codes.
package ils_pkg;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_ZERO     = 3'd1,
      PH_HEXSTART = 3'd2,
      PH_DIGITS   = 3'd3,
      PH_SUFFIX   = 3'd4
   } phase_type;

   typedef logic [2:0] err_type;

   localparam err_type ERR_NONE      = 3'd0;
   localparam err_type ERR_BAD_HEX   = 3'd1;
   localparam err_type ERR_MANY_L    = 3'd2;
   localparam err_type ERR_OVER_32   = 3'd3;
   localparam err_type ERR_NOT_DIGIT = 3'd4;

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_U  = 8'h75;
   localparam logic [7:0] CH_UP_U  = 8'h55;
   localparam logic [7:0] CH_LO_L  = 8'h6C;
   localparam logic [7:0] CH_UP_L  = 8'h4C;

   localparam logic [1:0] ELL_MAX  = 2'd3;
   localparam logic [1:0] ELL_LONG = 2'd2;

endpackage

// ===== hdl/ils_req_if.sv =====
// Character request channel of the integer literal scanner.
interface ils_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_input;

   modport source(output valid, output char_code, output end_of_input, input ready);
   modport sink(input valid, input char_code, input end_of_input, output ready);
endinterface

// ===== hdl/ils_rsp_if.sv =====
// Literal response channel of the integer literal scanner.
interface ils_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic        is_long_long;
   logic [2:0]  error_code;
   logic        terminator_consumed;

   modport source(output valid, output value, output is_long_long, output error_code,
                  output terminator_consumed, input ready);
   modport sink(input valid, input value, input is_long_long, input error_code,
                input terminator_consumed, output ready);
endinterface

// ===== hdl/integer_literal_scanner.sv =====
// Integer literal scanner: top level with scan state, datapath and response register.
//
// Usage: characters of the source arrive on req_if, one byte per transfer, with
// end_of_input marking the end of the source. The block scans one C integer
// literal (decimal, or hexadecimal after a leading 0x) followed by u/l suffixes.
// When a character ends the literal, or the literal is malformed, one response
// goes out on rsp_if; terminator_consumed = 0 means the character that ended it
// must be presented again as the start of the next token.
// csr_we/csr_wdata write skip_mode; the user must write it only while the block is
// idle; the block does not enforce it. Rate: one character per cycle while
// req_if.ready is high. Each character takes a single pass through the 64-bit
// multiply-by-10 (multiply-by-16 in hex mode) shift-and-add datapath into the scan
// state registers; a response is visible on rsp_if the cycle after its transfer.
// Stalls: req_if.ready stays high while the response register is empty or
// is being emptied in the same cycle; when the receiver holds rsp_if.ready low
// with a response waiting, requests are held off.
// Reset: synchronous; clears the scan state, skip_mode and the response valid.
module integer_literal_scanner (
   input  logic             clock,
   input  logic             reset,
   ils_req_if.sink          req_if,
   ils_rsp_if.source        rsp_if,
   input  logic             csr_we,
   input  logic             csr_wdata
);
   import ils_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic        hex_ff, hex_in;
   logic [1:0]  ell_ff, ell_in;
   logic        skip_ff;

   logic        rsp_valid_ff;
   logic [63:0] rsp_value_ff;
   logic        rsp_ll_ff;
   err_type     rsp_err_ff;
   logic        rsp_used_ff;

   logic        accept;
   logic [7:0]  c;
   logic        eoi;
   logic        is_dec, is_hex, is_x, is_ell, is_suffix;
   logic [3:0]  hv;
   logic        take_digit;
   logic [63:0] acc_mac;

   logic        emit;
   logic [63:0] emit_value;
   logic        emit_ll;
   err_type     emit_err;
   logic        emit_used;

   logic [63:0] fin_value;
   logic        fin_ll;
   err_type     fin_err;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign c            = req_if.char_code;
   assign eoi          = req_if.end_of_input;

   // Character classes.
   always_comb begin
      is_dec    = !eoi && (c >= CH_0) && (c <= CH_9);
      is_hex    = 1'b1;
      hv        = 4'd0;
      if ((c >= CH_0) && (c <= CH_9)) begin
         hv = 4'(c - CH_0);
      end else if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
         hv = 4'(c - CH_LO_A + 8'd10);
      end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
         hv = 4'(c - CH_UP_A + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
      is_hex    = is_hex && !eoi;
      is_x      = !eoi && ((c == CH_LO_X) || (c == CH_UP_X));
      is_ell    = !eoi && ((c == CH_LO_L) || (c == CH_UP_L));
      is_suffix = is_ell || (!eoi && ((c == CH_LO_U) || (c == CH_UP_U)));
   end

   assign take_digit = hex_ff ? is_hex : is_dec;
   assign acc_mac    = hex_ff ? {acc_ff[59:0], hv}
                              : (acc_ff << 3) + (acc_ff << 1) + {60'd0, hv};

   // Result of a literal that ends normally.
   always_comb begin
      fin_value = 64'd0;
      fin_ll    = 1'b0;
      fin_err   = ERR_NONE;
      if (ell_ff == ELL_MAX) begin
         fin_err = ERR_MANY_L;
      end else if (ell_ff == ELL_LONG) begin
         fin_value = acc_ff;
         fin_ll    = 1'b1;
      end else if (skip_ff) begin
         fin_value = 64'd0;
      end else if (acc_ff[63:32] != 32'd0) begin
         fin_err = ERR_OVER_32;
      end else begin
         fin_value = {32'd0, acc_ff[31:0]};
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_ZERO: begin
            if (is_x)            phase_in = PH_HEXSTART;
            else if (take_digit) phase_in = PH_DIGITS;
            else if (is_suffix)  phase_in = PH_SUFFIX;
            else                 phase_in = PH_IDLE;
         end
         PH_HEXSTART: begin
            phase_in = is_hex ? PH_DIGITS : PH_IDLE;
         end
         PH_DIGITS: begin
            if (take_digit)     phase_in = PH_DIGITS;
            else if (is_suffix) phase_in = PH_SUFFIX;
            else                phase_in = PH_IDLE;
         end
         PH_SUFFIX: begin
            phase_in = is_suffix ? PH_SUFFIX : PH_IDLE;
         end
         default: begin
            if (!is_dec)           phase_in = PH_IDLE;
            else if (c == CH_0)    phase_in = PH_ZERO;
            else                   phase_in = PH_DIGITS;
         end
      endcase
   end

   // Datapath and response.
   always_comb begin
      acc_in     = acc_ff;
      hex_in     = hex_ff;
      ell_in     = ell_ff;
      emit       = 1'b0;
      emit_value = 64'd0;
      emit_ll    = 1'b0;
      emit_err   = ERR_NONE;
      emit_used  = 1'b0;
      unique case (phase_ff) inside
         PH_HEXSTART: begin
            if (is_hex) begin
               acc_in = {60'd0, hv};
            end else begin
               emit      = 1'b1;
               emit_err  = ERR_BAD_HEX;
               emit_used = !eoi;
            end
         end
         PH_ZERO, PH_DIGITS, PH_SUFFIX: begin
            if (phase_ff == PH_ZERO && is_x) begin
               hex_in = 1'b1;
            end else if (phase_ff != PH_SUFFIX && take_digit) begin
               acc_in = acc_mac;
            end else if (is_suffix) begin
               if (is_ell && ell_ff != ELL_MAX) ell_in = ell_ff + 2'd1;
            end else begin
               emit       = 1'b1;
               emit_value = fin_value;
               emit_ll    = fin_ll;
               emit_err   = fin_err;
            end
         end
         default: begin
            if (is_dec) begin
               acc_in = {60'd0, hv};
               hex_in = 1'b0;
               ell_in = 2'd0;
            end else begin
               emit     = 1'b1;
               emit_err = ERR_NOT_DIGIT;
            end
         end
      endcase
      // Any response returns the scanner to a clean idle state.
      if (emit) begin
         acc_in = 64'd0;
         hex_in = 1'b0;
         ell_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= 64'd0;
         hex_ff   <= 1'b0;
         ell_ff   <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         hex_ff   <= hex_in;
         ell_ff   <= ell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b0;
      end else if (csr_we) begin
         skip_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_value_ff <= emit_value;
         rsp_ll_ff    <= emit_ll;
         rsp_err_ff   <= emit_err;
         rsp_used_ff  <= emit_used;
      end
   end

   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.value               = rsp_value_ff;
   assign rsp_if.is_long_long        = rsp_ll_ff;
   assign rsp_if.error_code          = rsp_err_ff;
   assign rsp_if.terminator_consumed = rsp_used_ff;

   a_err_clears_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff != ERR_NONE) |-> (rsp_value_ff == 64'd0 && !rsp_ll_ff))
      else $error("error response carries a nonzero value or long long flag");

   a_consumed_only_bad_hex: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_used_ff) |-> (rsp_err_ff == ERR_BAD_HEX))
      else $error("terminator consumed on a response that is not a bad hex start");

   a_short_fits_32: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ll_ff) |-> (rsp_value_ff[63:32] == 32'd0))
      else $error("value without long long suffix exceeds 32 bits");

   a_emit_clears_state: assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> (phase_ff == PH_IDLE && acc_ff == 64'd0 && ell_ff == 2'd0))
      else $error("scan state not cleared after a response");

   a_hexstart_in_hex: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEXSTART) |-> hex_ff)
      else $error("hex start phase without hex mode");

endmodule

// ===== sim/tb.sv =====
// Testbench for the integer literal scanner: directed table, random literal streams, checking.
`timescale 1ns / 100ps

module tb;
   import ils_pkg::*;

   typedef struct packed {
      logic [63:0] value;
      logic        is_long_long;
      err_type     error_code;
      logic        terminator_consumed;
   } literal_type;

   typedef struct packed {
      logic [7:0]  ch;
      logic        eoi;
      logic        typed;
      literal_type want;
   } char_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   ils_req_if req_if ();
   ils_rsp_if rsp_if ();

   integer_literal_scanner i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Scanner state as the testbench sees it.
   phase_type   scan_phase;
   logic [63:0] scan_acc;
   logic        scan_hex;
   logic [1:0]  scan_ells;
   logic        skip_copy;

   literal_type  pending_literals[$];
   char_row_type char_table[$];

   int mismatch_count;
   int char_count;
   int phase_start;
   int send_idle_pct;
   int recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("tb: done, errors");
      $finish;
   end

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return {1'b0, c[3:0]};
      if (c >= CH_LO_A && c <= CH_LO_F) return 5'(c - CH_LO_A + 8'd10);
      if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A + 8'd10);
      return 5'h10;
   endfunction

   function void scan_clear();
      scan_phase = PH_IDLE;
      scan_acc   = 64'd0;
      scan_hex   = 1'b0;
      scan_ells  = 2'd0;
   endfunction

   function automatic literal_type close_literal(input logic [63:0] v, input logic ll,
                                                 input err_type e, input logic used);
      scan_clear();
      return {v, ll, e, used};
   endfunction

   // Advances the scanner by one character; returns 1 when a literal result comes out.
   function automatic bit scan_char(input logic [7:0] ch, input logic eoi,
                                    output literal_type res);
      logic [4:0] hd;
      logic       dec;
      hd  = hex_digit(ch);
      dec = !eoi && ch >= CH_0 && ch <= CH_9;
      res = '0;
      case (scan_phase) inside
         PH_ZERO: begin
            if (!eoi && (ch == CH_LO_X || ch == CH_UP_X)) begin
               scan_phase = PH_HEXSTART;
               scan_hex   = 1'b1;
               return 1'b0;
            end
            scan_phase = PH_DIGITS;
         end
         PH_HEXSTART: begin
            if (eoi) begin
               res = close_literal(64'd0, 1'b0, ERR_BAD_HEX, 1'b0);
               return 1'b1;
            end
            if (hd[4]) begin
               res = close_literal(64'd0, 1'b0, ERR_BAD_HEX, 1'b1);
               return 1'b1;
            end
            scan_acc   = {60'd0, hd[3:0]};
            scan_phase = PH_DIGITS;
            return 1'b0;
         end
         PH_DIGITS, PH_SUFFIX: begin
         end
         default: begin
            if (!dec) begin
               res = close_literal(64'd0, 1'b0, ERR_NOT_DIGIT, 1'b0);
               return 1'b1;
            end
            scan_acc   = {60'd0, ch[3:0]};
            scan_hex   = 1'b0;
            scan_ells  = 2'd0;
            scan_phase = (ch == CH_0) ? PH_ZERO : PH_DIGITS;
            return 1'b0;
         end
      endcase

      if (scan_phase == PH_DIGITS) begin
         if (scan_hex && !eoi && !hd[4]) begin
            scan_acc = scan_acc * 64'd16 + {60'd0, hd[3:0]};
            return 1'b0;
         end
         if (!scan_hex && dec) begin
            scan_acc = scan_acc * 64'd10 + {60'd0, ch[3:0]};
            return 1'b0;
         end
      end
      if (!eoi && (ch == CH_LO_U || ch == CH_UP_U || ch == CH_LO_L || ch == CH_UP_L)) begin
         scan_phase = PH_SUFFIX;
         if ((ch == CH_LO_L || ch == CH_UP_L) && scan_ells < ELL_MAX) scan_ells = scan_ells + 2'd1;
         return 1'b0;
      end

      // The literal has ended; too many l is checked before the 32-bit range.
      if (scan_ells == ELL_MAX)
         res = close_literal(64'd0, 1'b0, ERR_MANY_L, 1'b0);
      else if (scan_ells == ELL_LONG)
         res = close_literal(scan_acc, 1'b1, ERR_NONE, 1'b0);
      else if (skip_copy)
         res = close_literal(64'd0, 1'b0, ERR_NONE, 1'b0);
      else if (scan_acc[63:32] != 32'd0)
         res = close_literal(64'd0, 1'b0, ERR_OVER_32, 1'b0);
      else
         res = close_literal({32'd0, scan_acc[31:0]}, 1'b0, ERR_NONE, 1'b0);
      return 1'b1;
   endfunction

   // Presents one character and waits for its transfer. Valid is only lowered in a gap,
   // so back-to-back characters never see a low and a high in the same step.
   task automatic put_char(input logic [7:0] ch, input logic eoi, input logic typed,
                           input literal_type want);
      literal_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.char_code    <= ch;
      req_if.end_of_input <= eoi;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      char_count++;
      if (scan_char(ch, eoi, got) || typed)
         pending_literals.push_back(typed ? want : got);
   endtask

   task automatic drain();
      int waited;
      req_if.valid <= 1'b0;
      waited = 0;
      while (pending_literals.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_literals.size() != 0) begin
         $error("%0d literal results never arrived", pending_literals.size());
         mismatch_count++;
         pending_literals.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_skip(input logic v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      skip_copy = v;
   endtask

   task automatic add_plain(input logic [7:0] ch);
      char_table.push_back({ch, 1'b0, 1'b0, literal_type'('0)});
   endtask

   task automatic add_checked(input logic [7:0] ch, input logic eoi, input logic [63:0] v,
                              input logic ll, input err_type e, input logic used);
      char_table.push_back({ch, eoi, 1'b1, v, ll, e, used});
   endtask

   function automatic logic [7:0] suffix_char();
      case ($urandom_range(3))
         0: return CH_LO_U;
         1: return CH_UP_U;
         2: return CH_LO_L;
         default: return CH_UP_L;
      endcase
   endfunction

   // Mostly well-formed literals with random content, plus broken hex starts and noise.
   task automatic random_token();
      int         kind;
      int         ndig;
      int         nsuf;
      int         r;
      bit         hexlit;
      bit         all_f;
      logic [7:0] c;
      kind = $urandom_range(99);
      if (kind < 80) begin
         hexlit = ($urandom_range(2) == 0);
         all_f  = ($urandom_range(3) == 0);
         r      = $urandom_range(9);
         ndig   = (r < 6) ? $urandom_range(6, 1) :
                  (r < 8) ? $urandom_range(11, 7) : $urandom_range(22, 12);
         if (hexlit) begin
            put_char(CH_0, 1'b0, 1'b0, '0);
            put_char($urandom_range(1) ? CH_LO_X : CH_UP_X, 1'b0, 1'b0, '0);
            repeat (ndig) begin
               r = all_f ? 15 : $urandom_range(15);
               if (r < 10)
                  c = CH_0 + 8'(r);
               else
                  c = ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'(r - 10);
               put_char(c, 1'b0, 1'b0, '0);
            end
         end else begin
            repeat (ndig) put_char(all_f ? CH_9 : CH_0 + 8'($urandom_range(9)),
                                   1'b0, 1'b0, '0);
         end
         nsuf = $urandom_range(4);
         repeat (nsuf) put_char(suffix_char(), 1'b0, 1'b0, '0);
         r = $urandom_range(9);
         if (r < 3)
            put_char(8'($urandom_range(255)), 1'b1, 1'b0, '0);
         else if (r < 6)
            put_char($urandom_range(1) ? 8'h20 : 8'h3B, 1'b0, 1'b0, '0);
         else
            put_char(8'($urandom_range(255)), 1'b0, 1'b0, '0);
      end else if (kind < 90) begin
         put_char(CH_0, 1'b0, 1'b0, '0);
         put_char($urandom_range(1) ? CH_LO_X : CH_UP_X, 1'b0, 1'b0, '0);
         do c = 8'($urandom_range(255)); while (hex_digit(c) < 5'h10);
         put_char(c, ($urandom_range(3) == 0), 1'b0, '0);
      end else begin
         repeat ($urandom_range(4, 1))
            put_char(8'($urandom_range(255)), ($urandom_range(9) == 0), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_rsp
      literal_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_literals.size() == 0) begin
            $error("response transfer with no literal expected");
            mismatch_count++;
         end else begin
            want = pending_literals.pop_front();
            if (rsp_if.value !== want.value) begin
               $error("value: expected %h, got %h", want.value, rsp_if.value);
               mismatch_count++;
            end
            if (rsp_if.is_long_long !== want.is_long_long) begin
               $error("is_long_long: expected %b, got %b", want.is_long_long,
                      rsp_if.is_long_long);
               mismatch_count++;
            end
            if (rsp_if.error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code,
                      rsp_if.error_code);
               mismatch_count++;
            end
            if (rsp_if.terminator_consumed !== want.terminator_consumed) begin
               $error("terminator_consumed: expected %b, got %b",
                      want.terminator_consumed, rsp_if.terminator_consumed);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      mismatch_count      = 0;
      char_count          = 0;
      send_idle_pct       = 31;
      recv_idle_pct       = 31;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_wdata           <= 1'b0;
      req_if.valid        <= 1'b0;
      req_if.char_code    <= 8'd0;
      req_if.end_of_input <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      scan_clear();
      skip_copy = 1'b0;

      // End of input right after reset, and a non-digit just below '0'.
      add_checked(8'hFF, 1'b1, 64'd0, 1'b0, ERR_NOT_DIGIT, 1'b0);
      add_checked(8'h2F, 1'b0, 64'd0, 1'b0, ERR_NOT_DIGIT, 1'b0);
      // 0x followed by a non-hex character, which is taken.
      add_plain(CH_0);
      add_plain(CH_LO_X);
      add_checked(8'h67, 1'b0, 64'd0, 1'b0, ERR_BAD_HEX, 1'b1);
      // 0X followed by end of input.
      add_plain(CH_0);
      add_plain(CH_UP_X);
      add_checked(8'h00, 1'b1, 64'd0, 1'b0, ERR_BAD_HEX, 1'b0);
      // Leading zero stays decimal; three l letters of mixed case are too many.
      add_plain(CH_0);
      add_plain(CH_9);
      add_plain(CH_LO_L);
      add_plain(CH_UP_L);
      add_plain(CH_UP_L);
      add_checked(8'h00, 1'b0, 64'd0, 1'b0, ERR_MANY_L, 1'b0);
      // 0x100000000U just passes 32 bits.
      add_plain(CH_0);
      add_plain(CH_LO_X);
      add_plain(CH_0 + 8'd1);
      repeat (8) add_plain(CH_0);
      add_plain(CH_UP_U);
      add_checked(8'h00, 1'b1, 64'd0, 1'b0, ERR_OVER_32, 1'b0);

      foreach (char_table[i])
         put_char(char_table[i].ch, char_table[i].eoi, char_table[i].typed,
                  char_table[i].want);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_skip(ph % 2 == 0);
         send_idle_pct = (ph == 3) ? 0 : 31;
         recv_idle_pct = (ph == 3) ? 0 : 31;
         phase_start   = char_count;
         while (char_count - phase_start < 175) begin
            random_token();
            if ($urandom_range(39) == 0) drain();
         end
         // End of input leaves the scanner idle before the next register write.
         put_char(8'($urandom_range(255)), 1'b1, 1'b0, '0);
         drain();
      end

      if (mismatch_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ils_pkg.sv
hdl/ils_req_if.sv
hdl/ils_rsp_if.sv
hdl/integer_literal_scanner.sv
sim/tb.sv
